FILE: rtl/core/aqlr_pkg.sv
// Shared types and codes for the alarm queue with lazy re-arm.
`timescale 1ns / 1ps
`default_nettype none

package aqlr_pkg;

  // Field widths fixed by the interface
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_W     = 42;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned MS_PER_S = 1000;

  // Op codes carried on the input tuser
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [TIME_W-1:0] key;
  } cell_ctrl_t;

  // What one cell shows to its neighbors
  typedef struct packed {
    logic              vld;
    logic              gt;
    logic [TIME_W-1:0] val;
  } cell_link_t;

endpackage

`default_nettype wire

FILE: rtl/core/aqlr_cell.sv
// One cell of the sorted alarm chain: holds one time and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module aqlr_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire aqlr_pkg::cell_ctrl_t    ctrl_i,
  input  wire aqlr_pkg::cell_link_t    left_i,
  input  wire aqlr_pkg::cell_link_t    right_i,
  output aqlr_pkg::cell_link_t         link_o,
  output logic                         eq_o
);
  import aqlr_pkg::*;

  logic              vld_q, vld_d;
  logic [TIME_W-1:0] val_q, val_d;
  logic              cmp_gt, cmp_eq, self_gt, self_ge;

  // Compare the held time against the broadcast key
  assign cmp_gt  = val_q > ctrl_i.key;
  assign cmp_eq  = val_q == ctrl_i.key;
  assign self_gt = !vld_q || cmp_gt;
  assign self_ge = vld_q && (cmp_gt || cmp_eq);

  assign link_o.vld = vld_q;
  assign link_o.gt  = self_gt;
  assign link_o.val = val_q;
  assign eq_o       = vld_q && cmp_eq;

  // Insert: open a gap at the first later cell; remove: close the gap over the match
  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctrl_i.ins && self_gt) begin
      if (left_i.gt) begin
        vld_d = left_i.vld;
        val_d = left_i.val;
      end else begin
        vld_d = 1'b1;
        val_d = ctrl_i.key;
      end
    end else if (ctrl_i.del && self_ge) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the time
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/alarm_queue_with_lazy_rearm.sv
// Top level: sorted cell chain of alarm times, re-arm decision and stream ports.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser op, tdata alarm_time
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser command, tdata result fields
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i min_update_diff
//
// Each item passes through accept, one chain shift, re-arm decision, and the
// times-1000 product loaded into the output register; the chain shift is the
// single step that touches all cells. The output register lets the next item
// be accepted while a result waits; an item then stalls in its last step.
// Reset empties the chain at once, clears the registered time and hysteresis.
`timescale 1ns / 1ps
`default_nettype none

module alarm_queue_with_lazy_rearm #(
  parameter int unsigned QUEUE_DEPTH = 64,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_BITS   = aqlr_pkg::MS_W + aqlr_pkg::TIME_W
                                       + aqlr_pkg::STAT_W + CNT_W,
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [aqlr_pkg::TIME_W-1:0]   s_axis_tdata,  // alarm_time
  input  wire logic                          s_axis_tuser,  // op
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // alarm_ms, registered_time, status, queue_count, zero fill
  output logic [OUT_W-1:0]                   m_axis_tdata,
  output logic [aqlr_pkg::CMD_W-1:0]         m_axis_tuser,  // command
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [aqlr_pkg::TIME_W-1:0]   cfg_data_i     // min_update_diff
);
  import aqlr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_DECIDE,
    S_EMIT
  } state_e;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  state_e              state_q;
  logic                op_q;
  logic [TIME_W-1:0]   key_q;
  logic [STAT_W-1:0]   status_q;
  logic                ins_done_q;
  logic [CNT_W-1:0]    count_q;
  logic [TIME_W-1:0]   armed_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [TIME_W-1:0]   diff_q;

  logic                m_valid_q;
  logic [CMD_W-1:0]    m_cmd_q;
  logic [MS_W-1:0]     m_ms_q;
  logic [TIME_W-1:0]   m_reg_q;
  logic [STAT_W-1:0]   m_stat_q;
  logic [CNT_W-1:0]    m_cnt_q;

  cell_ctrl_t          ctrl;
  cell_link_t          links [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_eq;
  logic [QUEUE_DEPTH-1:0] cell_vld;
  logic                found;
  logic                is_full;
  logic                key_zero;
  logic                out_free;
  logic [TIME_W:0]     add_sum;
  logic [TIME_W:0]     rem_sum;

  // Broadcast shift control during the shift step
  assign found    = |cell_eq;
  assign is_full  = count_q == FULL_CNT;
  assign key_zero = key_q == '0;

  assign ctrl.key = key_q;
  assign ctrl.ins = (state_q == S_SHIFT) && (op_q == OP_ADD) && !key_zero && !is_full;
  assign ctrl.del = (state_q == S_SHIFT) && (op_q == OP_REMOVE) && found;

  // Build the chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = '{vld: 1'b1, gt: 1'b0, val: '0};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_l = '{vld: 1'b0, gt: 1'b1, val: '0};
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end

    aqlr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (links[i]),
      .eq_o    (cell_eq[i])
    );

    assign cell_vld[i] = links[i].vld;
  end

  // Compare against sums at 33 bits
  assign add_sum = {1'b0, key_q} + {1'b0, diff_q};
  assign rem_sum = {1'b0, armed_q} + {1'b0, diff_q};

  assign out_free = !m_valid_q || m_axis_tready;

  // Sequence one item and hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_ADD;
      key_q      <= '0;
      status_q   <= ST_OK;
      ins_done_q <= 1'b0;
      count_q    <= '0;
      armed_q    <= '0;
      cmd_q      <= CMD_NONE;
      m_valid_q  <= 1'b0;
      m_cmd_q    <= CMD_NONE;
      m_ms_q     <= '0;
      m_reg_q    <= '0;
      m_stat_q   <= ST_OK;
      m_cnt_q    <= '0;
    end else begin
      // Drop the beat once taken, unless a new one loads in its place
      if (m_valid_q && m_axis_tready && state_q != S_EMIT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser;
            key_q   <= s_axis_tdata;
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          ins_done_q <= ctrl.ins;
          if (op_q == OP_ADD) begin
            if (key_zero) begin
              status_q <= ST_ZERO;
            end else if (is_full) begin
              status_q <= ST_FULL;
            end else begin
              status_q <= ST_OK;
              count_q  <= count_q + CNT_W'(1);
            end
          end else begin
            if (found) begin
              status_q <= ST_OK;
              count_q  <= count_q - CNT_W'(1);
            end else begin
              status_q <= ST_NOTFOUND;
            end
          end
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (op_q == OP_ADD) begin
            if (ins_done_q && (armed_q == '0 || add_sum < {1'b0, armed_q})) begin
              armed_q <= key_q;
              cmd_q   <= CMD_SET;
            end else begin
              cmd_q   <= CMD_NONE;
            end
          end else if (count_q == '0) begin
            armed_q <= '0;
            cmd_q   <= CMD_CANCEL;
          end else if ({1'b0, links[0].val} > rem_sum) begin
            armed_q <= links[0].val;
            cmd_q   <= CMD_SET;
          end else begin
            cmd_q   <= CMD_NONE;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_cmd_q   <= cmd_q;
            m_ms_q    <= (cmd_q == CMD_SET) ? MS_W'(armed_q) * MS_W'(MS_PER_S) : '0;
            m_reg_q   <= armed_q;
            m_stat_q  <= status_q;
            m_cnt_q   <= count_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Take hysteresis writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
    end else if (cfg_valid_i) begin
      diff_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_cmd_q;
  assign m_axis_tdata  = OUT_W'({m_cnt_q, m_stat_q, m_reg_q, m_ms_q});

`ifndef SYNTH
  // Fill count never exceeds the chain
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue count above depth");

  // Occupied cells match the fill count once an item has settled
  a_count_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(cell_vld) == 32'(count_q))
    else $error("cell occupancy differs from count");

  // Head of the chain is the smallest time
  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    links[1].vld |-> links[0].vld && links[0].val <= links[1].val)
    else $error("chain head out of order");

  // A cancel always leaves nothing registered and nothing queued
  a_cancel_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_cmd_q == CMD_CANCEL |-> m_reg_q == '0 && m_cnt_q == '0)
    else $error("cancel with pending alarms");

  // Registered time is nonzero whenever a set is reported
  a_set_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_cmd_q == CMD_SET |-> m_reg_q != '0 && m_ms_q != '0)
    else $error("set with zero time");
`endif

endmodule

`default_nettype wire

FILE: tb/aqlr_checker.sv
// Checker for the alarm queue: mirrors the queue and re-arm logic and compares result beats.
`timescale 1ns / 1ps

module aqlr_checker #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned CNT_W       = 7,
  parameter int unsigned OUT_W       = 88
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [aqlr_pkg::TIME_W-1:0]   s_tdata_i,   // alarm_time
  input  logic                          s_tuser_i,   // op
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // alarm_ms, registered_time, status, queue_count, zero fill
  input  logic [OUT_W-1:0]              m_tdata_i,
  input  logic [aqlr_pkg::CMD_W-1:0]    m_tuser_i,   // command
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [aqlr_pkg::TIME_W-1:0]   cfg_data_i,  // min_update_diff
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_count_o
);
  import aqlr_pkg::*;

  // Bit offsets of the result fields inside tdata
  localparam int unsigned REG_LSB  = MS_W;
  localparam int unsigned STAT_LSB = MS_W + TIME_W;
  localparam int unsigned CNT_LSB  = MS_W + TIME_W + STAT_W;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [MS_W-1:0]   alarm_ms;
    logic [TIME_W-1:0] registered_time;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  queue_count;
  } alarm_result_t;

  // Shadow of the queue contents and the registered alarm
  logic [TIME_W-1:0] slot_time [QUEUE_DEPTH];
  logic              slot_used [QUEUE_DEPTH];
  logic [CNT_W-1:0]  used_count;
  logic [TIME_W-1:0] armed_s;
  logic [TIME_W-1:0] hyst_s;

  alarm_result_t     awaited_results [$];
  int unsigned       mismatches;
  int unsigned       awaited_count;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = awaited_count;

  // Apply one add or remove to the shadow queue and form the result it yields
  task automatic apply_alarm_op(input logic op, input logic [TIME_W-1:0] t,
                                output alarm_result_t res);
    int                slot;
    int                i;
    logic              have;
    logic [TIME_W-1:0] soon;
    logic [TIME_W:0]   lhs;
    logic [TIME_W:0]   rhs;
    logic [MS_W-1:0]   wide_armed;
    res         = '0;
    res.command = CMD_NONE;
    res.status  = ST_OK;
    slot        = -1;
    if (op == OP_ADD) begin
      if (t == '0) begin
        res.status = ST_ZERO;
      end else begin
        for (i = 0; i < QUEUE_DEPTH; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_time[slot] = t;
          slot_used[slot] = 1'b1;
          used_count      = used_count + 1'b1;
          lhs = {1'b0, t} + {1'b0, hyst_s};
          rhs = {1'b0, armed_s};
          if (armed_s == '0 || lhs < rhs) begin
            armed_s     = t;
            res.command = CMD_SET;
          end
        end
      end
    end else begin
      for (i = 0; i < QUEUE_DEPTH; i++)
        if (slot < 0 && slot_used[i] && slot_time[i] == t) slot = i;
      if (slot < 0) begin
        res.status = ST_NOTFOUND;
      end else begin
        slot_used[slot] = 1'b0;
        used_count      = used_count - 1'b1;
      end
      // Empty check and lazy re-arm run even when nothing was removed
      if (used_count == '0) begin
        armed_s     = '0;
        res.command = CMD_CANCEL;
      end else begin
        have = 1'b0;
        soon = '0;
        for (i = 0; i < QUEUE_DEPTH; i++) begin
          if (slot_used[i] && (!have || slot_time[i] < soon)) begin
            soon = slot_time[i];
            have = 1'b1;
          end
        end
        lhs = {1'b0, soon};
        rhs = {1'b0, armed_s} + {1'b0, hyst_s};
        if (lhs > rhs) begin
          armed_s     = soon;
          res.command = CMD_SET;
        end
      end
    end
    wide_armed          = armed_s;
    res.alarm_ms        = (res.command == CMD_SET) ? wide_armed * MS_PER_S : '0;
    res.registered_time = armed_s;
    res.queue_count     = used_count;
  endtask

  // Compare each result beat with the oldest prediction, then predict new input beats
  always @(posedge clk_i or negedge rst_ni) begin
    alarm_result_t want;
    alarm_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_time[i] = '0;
        slot_used[i] = 1'b0;
      end
      used_count = '0;
      armed_s    = '0;
      hyst_s     = '0;
      awaited_results.delete();
      awaited_count = 0;
      mismatches    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.command         = m_tuser_i;
        got.alarm_ms        = m_tdata_i[MS_W-1:0];
        got.registered_time = m_tdata_i[REG_LSB +: TIME_W];
        got.status          = m_tdata_i[STAT_LSB +: STAT_W];
        got.queue_count     = m_tdata_i[CNT_LSB +: CNT_W];
        if (awaited_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got.command !== want.command) begin
            $error("command: expected %0d, got %0d", want.command, got.command);
            mismatches++;
          end
          if (got.alarm_ms !== want.alarm_ms) begin
            $error("alarm_ms: expected %0d, got %0d", want.alarm_ms, got.alarm_ms);
            mismatches++;
          end
          if (got.registered_time !== want.registered_time) begin
            $error("registered_time: expected %0d, got %0d",
                   want.registered_time, got.registered_time);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.queue_count !== want.queue_count) begin
            $error("queue_count: expected %0d, got %0d",
                   want.queue_count, got.queue_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) hyst_s = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        apply_alarm_op(s_tuser_i, s_tdata_i, want);
        awaited_results.push_back(want);
      end
      awaited_count = awaited_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the alarm queue: clock, reset, stimulus, sink stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
  import aqlr_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = ((MS_W + TIME_W + STAT_W + CNT_W + 7) / 8) * 8;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [TIME_W-1:0] s_axis_tdata;   // alarm_time
  logic              s_axis_tuser;   // op
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // alarm_ms, registered_time, status, queue_count, zero fill
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [CMD_W-1:0]  m_axis_tuser;   // command
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [TIME_W-1:0] cfg_data_i;     // min_update_diff

  int unsigned       mismatch_count;
  int unsigned       pending_count;

  // No idle cycles on either side while set
  logic              steady;
  // Times believed queued, used only to aim removes at live entries
  logic [TIME_W-1:0] live_times [$];

  alarm_queue_with_lazy_rearm #(
    .QUEUE_DEPTH (DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  aqlr_checker #(
    .QUEUE_DEPTH (DEPTH),
    .CNT_W       (CNT_W),
    .OUT_W       (OUT_W)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung handshake
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  // Drive one alarm beat after a random gap and hold it until accepted
  task automatic send_alarm_op(input logic op, input logic [TIME_W-1:0] t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = t;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop input, wait for every result, then let the pipeline settle
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_hysteresis(input logic [TIME_W-1:0] v);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mix of zero, clustered small times, times near the top and full-range times
  function automatic logic [TIME_W-1:0] rand_time();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick <= 4) return $urandom_range(1, 40);
    if (pick <= 6) return 32'hFFFF_FFFF - $urandom_range(0, 40);
    return $urandom;
  endfunction

  // Issue a random add or remove and keep the live list roughly in step
  task automatic random_alarm_op(input int add_pct);
    logic [TIME_W-1:0] t;
    int                idx;
    int                hit;
    if ($urandom_range(0, 99) < add_pct) begin
      t = rand_time();
      if (t != '0 && live_times.size() < DEPTH) live_times.push_back(t);
      send_alarm_op(OP_ADD, t);
    end else begin
      if (live_times.size() != 0 && $urandom_range(0, 99) < 80) begin
        idx = $urandom_range(0, live_times.size() - 1);
        t   = live_times[idx];
        live_times.delete(idx);
      end else begin
        t   = rand_time();
        hit = -1;
        for (idx = 0; idx < live_times.size(); idx++)
          if (hit < 0 && live_times[idx] == t) hit = idx;
        if (hit >= 0) live_times.delete(hit);
      end
      send_alarm_op(OP_REMOVE, t);
    end
  endtask

  // Result sink: random stall before each beat, none while steady
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [TIME_W-1:0] hyst_plan [8];
    rst_ni        = 1'b0;
    steady        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ADD;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset hysteresis of zero: empty remove, zero add, extremes, duplicates
    send_alarm_op(OP_REMOVE, '0);
    send_alarm_op(OP_ADD, '0);
    send_alarm_op(OP_ADD, 32'hFFFF_FFFF);
    send_alarm_op(OP_ADD, 32'd1);
    send_alarm_op(OP_ADD, 32'd1);
    send_alarm_op(OP_ADD, 32'd2);
    send_alarm_op(OP_REMOVE, 32'd1);
    send_alarm_op(OP_REMOVE, 32'd7);
    send_alarm_op(OP_REMOVE, 32'd1);
    send_alarm_op(OP_REMOVE, '0);
    send_alarm_op(OP_REMOVE, 32'd2);
    send_alarm_op(OP_REMOVE, 32'hFFFF_FFFF);
    send_alarm_op(OP_REMOVE, 32'hFFFF_FFFF);

    // Largest hysteresis: sums must not wrap
    write_hysteresis(32'hFFFF_FFFF);
    send_alarm_op(OP_ADD, 32'h8000_0000);
    send_alarm_op(OP_ADD, 32'd1);
    send_alarm_op(OP_ADD, 32'hFFFF_FFFF);
    send_alarm_op(OP_REMOVE, 32'd1);
    send_alarm_op(OP_REMOVE, 32'h8000_0000);
    send_alarm_op(OP_REMOVE, 32'hFFFF_FFFF);

    // Small hysteresis: edges of the earlier and later thresholds
    write_hysteresis(32'd3);
    send_alarm_op(OP_ADD, 32'd10);
    send_alarm_op(OP_ADD, 32'd7);
    send_alarm_op(OP_ADD, 32'd6);
    send_alarm_op(OP_REMOVE, 32'd6);
    send_alarm_op(OP_REMOVE, 32'd7);
    send_alarm_op(OP_REMOVE, 32'd10);

    // Random phases: alternate filling to full and draining to empty
    hyst_plan[0] = '0;
    hyst_plan[1] = 32'd1;
    hyst_plan[2] = 32'hFFFF_FFFF;
    hyst_plan[3] = 32'd5;
    hyst_plan[4] = 32'h8000_0000;
    hyst_plan[5] = $urandom;
    hyst_plan[6] = $urandom_range(0, 64);
    hyst_plan[7] = '0;
    for (int p = 0; p < 8; p++) begin
      steady = 1'b0;
      write_hysteresis(hyst_plan[p]);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 105; n++) random_alarm_op((p % 2 == 0) ? 88 : 12);
    end

    steady = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
